@@ rtl/fir24_pkg.sv @@
`timescale 1ns / 1ps

package fir24_pkg;

    // Filter geometry
    localparam int TAP_COUNT   = 63;
    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 32;

    // Delay line holds every tap but the current sample
    localparam int DEPTH     = TAP_COUNT - 1;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // Tap age counter, also reaches DEPTH itself
    localparam int K_BITS    = $clog2(DEPTH + 1);

    // Arithmetic widths
    localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS  = 64;
    localparam int FRAC_BITS = COEF_BITS - 1;

    // Saturation limits and the bias that makes the shift round toward zero
    localparam logic signed [ACC_BITS-1:0] SAT_HI =
        {{(ACC_BITS - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] SAT_LO = ~SAT_HI;
    localparam logic [ACC_BITS-1:0] TRUNC_BIAS =
        {{(ACC_BITS - FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}};

    // Coefficient ROM, signed Q1.31; entry 0 weights the oldest sample
    localparam int ROM_SIZE     = 63;
    localparam int ROM_IDX_BITS = $clog2(ROM_SIZE);
    localparam int COEF_ROM [ROM_SIZE] = '{
        0, 320, 1319, 3017, 5379, 8317, 11684, 15280,
        18850, 22095, 24671, 26203, 26289, 24517, 20472, 13754,
        3990, -9149, -25930, -46546, -71095, -99566, -131825, -167601,
        -206478, -247878, -291066, -335141, -379040, -421542, -461285, -496774,
        -526407, -548498, -561312, -563094, -552119, -526727, -485377, -426696,
        -349530, -252999, -136548, 0, 156399, 331934, 525385, 734994,
        958449, 1192866, 1434792, 1680215, 1924590, 2162877, 2389594, 2598883,
        2784592, 2940373, 3059782, 3136407, 3163995, 3136589, 0
    };

    // Control that travels with each tap through the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

    // Coefficient lookup; taps past the ROM weigh zero
    function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [K_BITS-1:0] idx);
        logic signed [COEF_BITS-1:0] c;
        c = '0;
        if (int'(idx) < ROM_SIZE) begin
            c = COEF_BITS'(COEF_ROM[ROM_IDX_BITS'(idx)]);
        end
        return c;
    endfunction

endpackage

@@ rtl/fir24_delay_mem.sv @@
`timescale 1ns / 1ps

// Circular delay-line storage, one write and one registered read per cycle
module fir24_delay_mem (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [fir24_pkg::ADDR_BITS-1:0]      wr_addr,
    input  logic [fir24_pkg::SAMPLE_BITS-1:0]    wr_data,
    input  logic                                 rd_en,
    input  logic [fir24_pkg::ADDR_BITS-1:0]      rd_addr,
    output logic [fir24_pkg::SAMPLE_BITS-1:0]    rd_data
);

    logic [fir24_pkg::SAMPLE_BITS-1:0] ram_reg [fir24_pkg::DEPTH];
    logic [fir24_pkg::SAMPLE_BITS-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram_reg[wr_addr] <= wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/fir24_mac.sv @@
`timescale 1ns / 1ps

// Shared multiply-accumulate: multiply, accumulate, then scale and clamp
module fir24_mac (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  fir24_pkg::mac_ctrl_t                        ctrl_i,
    input  logic signed [fir24_pkg::SAMPLE_BITS-1:0]    sample_i,
    input  logic signed [fir24_pkg::COEF_BITS-1:0]      coef_i,
    output logic                                        done_o,
    output logic [fir24_pkg::SAMPLE_BITS-1:0]           y_o
);

    localparam int PB = fir24_pkg::PROD_BITS;
    localparam int AB = fir24_pkg::ACC_BITS;

    fir24_pkg::mac_ctrl_t ctrl_a_reg, ctrl_b_reg;
    logic signed [PB-1:0] prod_reg;
    logic signed [PB-1:0] prod_next;
    logic signed [AB-1:0] acc_reg;
    logic signed [AB-1:0] acc_next;
    logic signed [AB-1:0] prod_ext;
    logic signed [AB-1:0] biased;
    logic signed [AB-1:0] quot;
    logic        [fir24_pkg::SAMPLE_BITS-1:0] y_next;
    logic        [fir24_pkg::SAMPLE_BITS-1:0] y_reg;
    logic        done_reg;

    // Stage A: product
    assign prod_next = sample_i * coef_i;

    // Stage B: running sum, restarted on the first tap
    assign prod_ext = {{(AB - PB){prod_reg[PB-1]}}, prod_reg};
    assign acc_next = ctrl_a_reg.first ? prod_ext : acc_reg + prod_ext;

    // Stage C: divide by 2^FRAC toward zero, then clamp
    always_comb begin
        biased = acc_reg;
        if (acc_reg[AB-1]) begin
            biased = acc_reg + fir24_pkg::TRUNC_BIAS;
        end
        quot = biased >>> fir24_pkg::FRAC_BITS;
        if (quot > fir24_pkg::SAT_HI) begin
            y_next = fir24_pkg::SAT_HI[fir24_pkg::SAMPLE_BITS-1:0];
        end else if (quot < fir24_pkg::SAT_LO) begin
            y_next = fir24_pkg::SAT_LO[fir24_pkg::SAMPLE_BITS-1:0];
        end else begin
            y_next = quot[fir24_pkg::SAMPLE_BITS-1:0];
        end
    end

    // Control pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_a_reg <= '0;
            ctrl_b_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            ctrl_a_reg <= ctrl_i;
            ctrl_b_reg <= ctrl_a_reg;
            done_reg   <= ctrl_b_reg.valid && ctrl_b_reg.last;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (ctrl_i.valid) begin
            prod_reg <= prod_next;
        end
        if (ctrl_a_reg.valid) begin
            acc_reg <= acc_next;
        end
        if (ctrl_b_reg.valid && ctrl_b_reg.last) begin
            y_reg <= y_next;
        end
    end

    assign done_o = done_reg;
    assign y_o    = y_reg;

endmodule

@@ rtl/fir_filter_24bit_saturating.sv @@
`timescale 1ns / 1ps

// Channel   Ports                              Width  Role
// s_        s_valid s_ready s_sample_in        24     raw sample in
// m_        m_valid m_ready m_sample_out       24     filtered or raw sample out
// cfg_      cfg_valid cfg_ready cfg_data       1      filter_select write
//
// A sample passes from its input beat through the tap pass (one MAC per tap,
// each older tap fetched from the single read port of the delay-line RAM, the
// current sample taken from its input register), the drain of the MAC pipeline
// and scale/clamp stage, the load of the output register and a return to idle.
// One sample is in work at a time.
// Reset clears the pointer and fill count; unwritten taps read as zero.
// A result waiting in the output register holds off the next write-back only.
module fir_filter_24bit_saturating (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [fir24_pkg::SAMPLE_BITS-1:0]   s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [fir24_pkg::SAMPLE_BITS-1:0]   m_sample_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data
);

    localparam int SB = fir24_pkg::SAMPLE_BITS;
    localparam int KB = fir24_pkg::K_BITS;
    localparam int AW = fir24_pkg::ADDR_BITS;
    localparam int SUM_BITS = KB + 1;
    localparam logic [KB-1:0] K_DEPTH = KB'(fir24_pkg::DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic                 filter_select_reg;
    logic [SB-1:0]        x_reg;
    logic [KB-1:0]        k_reg;
    logic [AW-1:0]        wp_reg;
    logic [KB-1:0]        fill_reg;
    logic                 m_valid_reg;
    logic [SB-1:0]        m_data_reg;

    // Issue-stage registers traveling beside the RAM read
    fir24_pkg::mac_ctrl_t             ctrl1_reg;
    logic                             cur1_reg;
    logic                             zero1_reg;
    logic signed [fir24_pkg::COEF_BITS-1:0] coef1_reg;

    logic [SUM_BITS-1:0]  addr_sum;
    logic [AW-1:0]        rd_addr;
    logic                 rd_en;
    logic                 wr_en;
    logic [SB-1:0]        rd_data;
    logic signed [SB-1:0] mac_sample;
    logic                 mac_done;
    logic [SB-1:0]        mac_y;
    logic                 out_free;
    logic [AW-1:0]        wp_next;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;
    assign wr_en     = (state_reg == ST_OUT) && out_free;
    assign rd_en     = (state_reg == ST_RUN) && (k_reg != '0);

    // Address of the sample k beats old: wp - k modulo DEPTH
    always_comb begin
        addr_sum = SUM_BITS'(wp_reg) + SUM_BITS'(K_DEPTH) - SUM_BITS'(k_reg);
        if (addr_sum >= SUM_BITS'(K_DEPTH)) begin
            addr_sum = addr_sum - SUM_BITS'(K_DEPTH);
        end
        rd_addr = addr_sum[AW-1:0];
    end

    // Write pointer wrap
    always_comb begin
        wp_next = wp_reg + AW'(1);
        if (wp_reg == AW'(fir24_pkg::DEPTH - 1)) begin
            wp_next = '0;
        end
    end

    // Tap operand: current sample, zero for never-written taps, or RAM data
    always_comb begin
        if (cur1_reg) begin
            mac_sample = x_reg;
        end else if (zero1_reg) begin
            mac_sample = '0;
        end else begin
            mac_sample = rd_data;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_select_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            filter_select_reg <= cfg_data;
        end
    end

    // Sequencer: state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            k_reg       <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
            ctrl1_reg   <= '0;
            cur1_reg    <= 1'b0;
            zero1_reg   <= 1'b0;
        end else begin
            ctrl1_reg.valid <= (state_reg == ST_RUN);
            ctrl1_reg.first <= (state_reg == ST_RUN) && (k_reg == K_DEPTH);
            ctrl1_reg.last  <= (state_reg == ST_RUN) && (k_reg == '0);
            if (m_valid_reg && m_ready && !wr_en) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        k_reg     <= K_DEPTH;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    cur1_reg        <= (k_reg == '0);
                    zero1_reg       <= (k_reg > fill_reg);
                    k_reg           <= k_reg - KB'(1);
                    if (k_reg == '0) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (mac_done) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        wp_reg      <= wp_next;
                        if (fill_reg != K_DEPTH) begin
                            fill_reg <= fill_reg + KB'(1);
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg <= s_sample_in;
        end
        if (state_reg == ST_RUN) begin
            coef1_reg <= fir24_pkg::coef_at(K_DEPTH - k_reg);
        end
        if (wr_en) begin
            m_data_reg <= filter_select_reg ? mac_y : x_reg;
        end
    end

    fir24_delay_mem u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (x_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fir24_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl_i   (ctrl1_reg),
        .sample_i (mac_sample),
        .coef_i   (coef1_reg),
        .done_o   (mac_done),
        .y_o      (mac_y)
    );

    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_data_reg;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int TAP_COUNT    = fir24_pkg::TAP_COUNT;
    localparam int SAMPLE_BITS  = fir24_pkg::SAMPLE_BITS;
    localparam int COEF_BITS    = fir24_pkg::COEF_BITS;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 6;
    localparam int MAX_WAIT     = 8;
    localparam int SETTLE       = 80;       // a bit over one sample's MAC pass
    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_AT      = 500;      // samples sent before the long output stall
    localparam int HOLD_CYCLES  = 700;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASES       = 5;
    localparam int RAND_HEAD    = 70;
    localparam int RAND_TAIL    = 73;
    localparam int BURST_LEN    = 25;

    localparam longint Q_ONE   = longint'(1) << (COEF_BITS - 1);
    localparam longint OUT_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;

    localparam logic [SAMPLE_BITS-1:0] POS_FULL = 24'h7FFFFF;
    localparam logic [SAMPLE_BITS-1:0] NEG_FULL = 24'h800000;

    // Q1.31 taps; entry 0 weights the oldest sample
    localparam int TAPS_Q31 [TAP_COUNT] = '{
        0, 320, 1319, 3017, 5379, 8317, 11684, 15280,
        18850, 22095, 24671, 26203, 26289, 24517, 20472, 13754,
        3990, -9149, -25930, -46546, -71095, -99566, -131825, -167601,
        -206478, -247878, -291066, -335141, -379040, -421542, -461285, -496774,
        -526407, -548498, -561312, -563094, -552119, -526727, -485377, -426696,
        -349530, -252999, -136548, 0, 156399, 331934, 525385, 734994,
        958449, 1192866, 1434792, 1680215, 1924590, 2162877, 2389594, 2598883,
        2784592, 2940373, 3059782, 3136407, 3163995, 3136589, 0
    };

    localparam logic [SAMPLE_BITS-1:0] EXTREME_SAMPLES [6] = '{
        24'h000000, 24'h000001, 24'h7FFFFF, 24'h800000, 24'h800001, 24'hFFFFFF
    };

    localparam logic [SAMPLE_BITS-1:0] RAW_DIRECTED [8] = '{
        24'h000000, 24'hFFFFFF, 24'h7FFFFF, 24'h800000,
        24'h000001, 24'hAAAAAA, 24'h555555, 24'h800000
    };

    localparam logic [SAMPLE_BITS-1:0] FILT_DIRECTED [12] = '{
        24'h7FFFFF, 24'h000000, 24'h000000, 24'h800000, 24'hFFFFFF, 24'h000001,
        24'h800001, 24'h7FFFFE, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000
    };

    localparam bit PHASE_SEL [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1};

    typedef enum logic [1:0] {
        BEAT_SAMPLE,
        BEAT_FILTER_SEL,
        BEAT_DRAIN
    } stim_kind_t;

    typedef struct {
        stim_kind_t              kind;
        logic [SAMPLE_BITS-1:0]  data;
        int                      gap;
    } stim_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [SAMPLE_BITS-1:0]  s_sample_in = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [SAMPLE_BITS-1:0]  m_sample_out;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic                    cfg_data = 1'b0;

    fir_filter_24bit_saturating uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // Filter state mirror and pending work
    logic signed [SAMPLE_BITS-1:0] fir_taps [TAP_COUNT-1] = '{default: '0};
    logic                          filter_on = 1'b0;
    stim_t                         pending_q [$];
    logic [SAMPLE_BITS-1:0]        expected_samples [$];
    bit                            tx_burst = 1'b0;

    int  sent_local = 0;     // driver-owned count of accepted samples
    int  sent_count = 0;     // same count, published by NBA
    int  results_seen = 0;
    int  mismatches = 0;
    int  gap_left = 0;
    bit  gap_loaded = 1'b0;
    int  rx_stall = 0;
    bit  rx_burst = 1'b0;
    logic rx_hold = 1'b0;
    int  hold_cnt = 0;
    bit  hold_done = 1'b0;
    int  cycles = 0;

    logic                   sv_n;
    logic                   cv_n;
    logic                   cd_n;
    logic [SAMPLE_BITS-1:0] sd_n;
    logic [SAMPLE_BITS-1:0] want;

    // Next output for one sample; advances the tap history either way
    function automatic logic [SAMPLE_BITS-1:0] filter_next_sample(
        input logic [SAMPLE_BITS-1:0] raw
    );
        longint acc;
        longint y;
        int     j;
        acc = longint'(TAPS_Q31[TAP_COUNT-1]) * longint'(signed'(raw));
        for (j = 1; j < TAP_COUNT; j++) begin
            acc += longint'(TAPS_Q31[TAP_COUNT-1-j]) * longint'(fir_taps[j-1]);
        end
        y = acc / Q_ONE;    // truncates toward zero
        if (y > OUT_MAX) y = OUT_MAX;
        if (y < OUT_MIN) y = OUT_MIN;
        for (j = TAP_COUNT - 2; j > 0; j--) begin
            fir_taps[j] = fir_taps[j-1];
        end
        fir_taps[0] = signed'(raw);
        return filter_on ? y[SAMPLE_BITS-1:0] : raw;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        logic [SAMPLE_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = SAMPLE_BITS'($urandom());
            2: v = EXTREME_SAMPLES[$urandom_range(0, 5)];
            3: v = SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
            4: begin
                v = SAMPLE_BITS'(1) << $urandom_range(0, SAMPLE_BITS - 1);
                if ($urandom_range(0, 1)) v = ~v;
            end
            default: v = {$urandom_range(0, 1) ? 4'hF : 4'h0, 20'($urandom())};
        endcase
        return v;
    endfunction

    task automatic add_sample(input logic [SAMPLE_BITS-1:0] v);
        stim_t it;
        it.kind = BEAT_SAMPLE;
        it.data = v;
        it.gap  = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        pending_q.push_back(it);
    endtask

    task automatic add_marker(input stim_kind_t k, input logic v);
        stim_t it;
        it.kind = k;
        it.data = SAMPLE_BITS'(v);
        it.gap  = 0;
        pending_q.push_back(it);
    endtask

    task automatic add_random(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            if (i % BURST_LEN == 0) tx_burst = ($urandom_range(0, 3) == 0);
            add_sample(random_sample());
        end
    endtask

    // Full-scale run whose signs follow the taps: drives the largest outputs
    task automatic add_peak_run(input bit invert);
        int i;
        bit pos;
        for (i = 0; i < TAP_COUNT; i++) begin
            pos = (TAPS_Q31[i] >= 0) ^ invert;
            add_sample(pos ? POS_FULL : NEG_FULL);
        end
    endtask

    // Clock
    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Stimulus, reset and end of run
    initial begin
        int p;
        int i;
        tx_burst = 1'b0;
        // raw path at the reset setting
        for (i = 0; i < 8; i++) add_sample(RAW_DIRECTED[i]);
        add_marker(BEAT_DRAIN, 1'b0);
        // filtered path, most taps still hold their reset zeros
        add_marker(BEAT_FILTER_SEL, 1'b1);
        for (i = 0; i < 12; i++) add_sample(FILT_DIRECTED[i]);
        add_marker(BEAT_DRAIN, 1'b0);
        for (p = 0; p < PHASES; p++) begin
            add_marker(BEAT_FILTER_SEL, PHASE_SEL[p]);
            add_random(RAND_HEAD);
            tx_burst = ($urandom_range(0, 1) == 1);
            add_peak_run(p[0]);
            add_random(RAND_TAIL);
            add_marker(BEAT_DRAIN, 1'b0);
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_q.size() != 0 || s_valid || cfg_valid || sent_count != results_seen)
            @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (expected_samples.size() != 0) begin
            $display("%0d expected samples never came out", expected_samples.size());
        end
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Input and config driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            cfg_valid  <= 1'b0;
            gap_left   = 0;
            gap_loaded = 1'b0;
        end else begin
            sv_n = s_valid;
            cv_n = cfg_valid;
            sd_n = s_sample_in;
            cd_n = cfg_data;
            if (s_valid && s_ready) begin
                expected_samples.push_back(filter_next_sample(s_sample_in));
                sent_local++;
                sv_n = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                filter_on = cfg_data;
                cv_n = 1'b0;
            end
            if (!sv_n && !cv_n && pending_q.size() != 0) begin
                case (pending_q[0].kind)
                    BEAT_SAMPLE: begin
                        if (!gap_loaded) begin
                            gap_left   = pending_q[0].gap;
                            gap_loaded = 1'b1;
                        end
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            sv_n = 1'b1;
                            sd_n = pending_q[0].data;
                            gap_loaded = 1'b0;
                            void'(pending_q.pop_front());
                        end
                    end
                    BEAT_FILTER_SEL: begin
                        // only while idle
                        if (sent_local == results_seen) begin
                            cv_n = 1'b1;
                            cd_n = pending_q[0].data[0];
                            void'(pending_q.pop_front());
                        end
                    end
                    BEAT_DRAIN: begin
                        if (sent_local == results_seen) void'(pending_q.pop_front());
                    end
                    default: void'(pending_q.pop_front());
                endcase
            end
            s_valid     <= sv_n;
            s_sample_in <= sd_n;
            cfg_valid   <= cv_n;
            cfg_data    <= cd_n;
            sent_count  <= sent_local;
        end
    end

    // Result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_stall = 0;
        end else begin
            rx_burst = ((results_seen / 97) % 4) == 2;
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: sample_out %h with nothing expected", $realtime,
                                 m_sample_out);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_sample_out !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: sample_out expected %h got %h", $realtime,
                                     want, m_sample_out);
                    end
                end
                results_seen <= results_seen + 1;
                rx_stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            end else if (rx_stall > 0) begin
                rx_stall--;
            end
            m_ready <= (rx_stall == 0) && !rx_hold;
        end
    end

    // One long output stall so the block backs up into its input
    always @(posedge aclk) begin
        if (!hold_done && sent_count >= HOLD_AT) begin
            if (hold_cnt == HOLD_CYCLES) begin
                rx_hold   <= 1'b0;
                hold_done = 1'b1;
            end else begin
                rx_hold <= 1'b1;
                hold_cnt++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
    end

endmodule

@@ sim.f @@
rtl/fir24_pkg.sv
rtl/fir24_delay_mem.sv
rtl/fir24_mac.sv
rtl/fir_filter_24bit_saturating.sv
tb/sv/tb_top.sv
